// ===== hw/rtl/ray_sphere_intersect_core_defines.svh =====
// assertion macros of the ray-sphere intersection rtl
`ifndef RAY_SPHERE_INTERSECT_CORE_DEFINES_SVH
`define RAY_SPHERE_INTERSECT_CORE_DEFINES_SVH

// same-cycle implication, checked on clk with arst_n as disable
`define RSI_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked on clk with arst_n as disable
`define RSI_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/rsi_pkg.sv =====
// constants and types of the ray-sphere intersection core
package rsi_pkg;

	localparam int FRAC_BITS = 16;
	localparam int CW        = 32;               // coordinate width
	localparam int RW        = 31;               // radius width
	localparam int DIRW      = 18;               // direction width
	localparam int DW        = CW + 1;           // origin minus center
	localparam int PW        = DW + DIRW;        // d * dir
	localparam int SQW       = 2 * DW;           // d * d
	localparam int SUMW      = SQW;              // sum of squares, unsigned
	localparam int RRW       = 2 * RW;           // radius squared
	localparam int BW        = 54;               // b = 2 * (d . dir), signed
	localparam int MAGW      = BW - 1;           // |b|
	localparam int LOW       = 26;               // low half of |b|
	localparam int HIW       = MAGW - LOW;       // high half of |b|
	localparam int BBW       = 2 * MAGW;         // b * b
	localparam int CCW       = SUMW + 1;         // sumsq - r*r, signed
	localparam int CSH       = 2 * FRAC_BITS + 2;
	localparam int DISCW     = 108;              // discriminant, signed
	localparam int SQRTW     = DISCW / 2;        // root bits
	localparam int REMW      = SQRTW + 3;        // partial remainder
	localparam int NW        = BW + 2;           // root numerator
	localparam int IDXW      = 2;
	localparam int IN_W      = 152;
	localparam int OUT_W     = 40;

	// configuration register indexes
	localparam logic [IDXW-1:0] REG_CENTER_X = 2'd0;
	localparam logic [IDXW-1:0] REG_CENTER_Y = 2'd1;
	localparam logic [IDXW-1:0] REG_CENTER_Z = 2'd2;
	localparam logic [IDXW-1:0] REG_RADIUS   = 2'd3;

	localparam logic signed [CW-1:0] MISS_DIST = -(CW'(1) << FRAC_BITS);
	localparam logic signed [CW-1:0] DIST_MAX  = {1'b0, {(CW-1){1'b1}}};
	localparam logic signed [CW-1:0] DIST_MIN  = {1'b1, {(CW-1){1'b0}}};

	// data that rides beside the root through the square-root pipe
	typedef struct packed {
		logic                 hit;
		logic signed [BW-1:0] b;
	} rsi_side_t;

endpackage

// ===== hw/rtl/rsi_sqrt.sv =====
// pipelined integer square root, one result bit per stage
module rsi_sqrt
	import rsi_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [DISCW-1:0] in_rad,
	input  rsi_side_t        in_side,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [SQRTW-1:0] out_root,
	output rsi_side_t        out_side
);

	logic             v_s    [0:SQRTW];
	logic             rdy    [1:SQRTW+1];
	logic [REMW-1:0]  rem_s  [0:SQRTW];
	logic [SQRTW-1:0] root_s [0:SQRTW];
	logic [DISCW-1:0] rad_s  [0:SQRTW];
	rsi_side_t        side_s [0:SQRTW];

	// entry of the pipe
	assign v_s[0]    = in_valid;
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign rad_s[0]  = in_rad;
	assign side_s[0] = in_side;
	assign rdy[SQRTW+1] = out_ready;
	assign in_ready  = rdy[1];

	for (genvar g = 0; g < SQRTW; g++) begin : g_bit
		logic [REMW-1:0] rem_sh;
		logic [REMW-1:0] trial;
		logic            ge;

		// bring down the next two radicand bits and try the next root bit
		assign rem_sh = {rem_s[g][REMW-3:0], rad_s[g][DISCW-1 -: 2]};
		assign trial  = {{(REMW-SQRTW-2){1'b0}}, root_s[g], 2'b01};
		assign ge     = (rem_sh >= trial);
		assign rdy[g+1] = !v_s[g+1] || rdy[g+2];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[g+1] <= 1'b0;
			end else if (rdy[g+1]) begin
				v_s[g+1] <= v_s[g];
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[g+1]) begin
				rem_s[g+1]  <= ge ? (rem_sh - trial) : rem_sh;
				root_s[g+1] <= {root_s[g][SQRTW-2:0], ge};
				rad_s[g+1]  <= {rad_s[g][DISCW-3:0], 2'b00};
				side_s[g+1] <= side_s[g];
			end
		end
	end

	// exit of the pipe
	assign out_valid = v_s[SQRTW];
	assign out_root  = root_s[SQRTW];
	assign out_side  = side_s[SQRTW];

endmodule

// ===== hw/rtl/ray_sphere_intersect_core.sv =====
// Ray-sphere intersection core: one ray per clock unless stalled, fully pipelined,
// Q16.16 fixed point. A request holds the ray origin and a unit direction; the result
// holds the hit flag, the distance to the nearer positive root less one LSB (farther
// root otherwise, -1.0 on a miss) and a saturation flag. It has seven arithmetic
// stages, 54 stages of the square root (one root bit per stage, set by the 108-bit
// discriminant) and two stages for root selection and clamping. A new ray may enter
// every cycle; a stalled output only backs up the stages that hold requests. Sphere
// center and radius must be written via the register port while idle (not enforced).
module ray_sphere_intersect_core
	import rsi_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	// register port
	input  logic             cfg_wen,
	input  logic [IDXW-1:0]  cfg_idx,
	input  logic [CW-1:0]    cfg_wdata,
	// ray requests
	input  logic             s_tvalid,
	output logic             s_tready,
	// origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, zero pad
	input  logic [IN_W-1:0]  s_tdata,
	// results
	output logic             m_tvalid,
	input  logic             m_tready,
	// hit, distance, saturated, zero pad
	output logic [OUT_W-1:0] m_tdata
);

	`include "ray_sphere_intersect_core_defines.svh"

	logic signed [CW-1:0] center_x_q, center_y_q, center_z_q;
	logic [RW-1:0]        radius_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q <= '0;
			center_y_q <= '0;
			center_z_q <= '0;
			radius_q   <= RW'(1) << FRAC_BITS;
		end else if (cfg_wen) begin
			unique case (cfg_idx)
				REG_CENTER_X: center_x_q <= cfg_wdata;
				REG_CENTER_Y: center_y_q <= cfg_wdata;
				REG_CENTER_Z: center_z_q <= cfg_wdata;
				REG_RADIUS:   radius_q   <= cfg_wdata[RW-1:0];
			endcase
		end
	end

	// request fields
	logic signed [CW-1:0]   ox, oy, oz;
	logic signed [DIRW-1:0] dx_in, dy_in, dz_in;
	assign ox    = s_tdata[CW-1:0];
	assign oy    = s_tdata[2*CW-1:CW];
	assign oz    = s_tdata[3*CW-1:2*CW];
	assign dx_in = s_tdata[3*CW+DIRW-1:3*CW];
	assign dy_in = s_tdata[3*CW+2*DIRW-1:3*CW+DIRW];
	assign dz_in = s_tdata[3*CW+3*DIRW-1:3*CW+2*DIRW];

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;
	logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6, rdy7, rdy8, rdy9;
	logic sq_in_ready, sq_out_valid;

	assign rdy9 = !v_s9 || m_tready;
	assign rdy8 = !v_s8 || rdy9;
	assign rdy7 = !v_s7 || sq_in_ready;
	assign rdy6 = !v_s6 || rdy7;
	assign rdy5 = !v_s5 || rdy6;
	assign rdy4 = !v_s4 || rdy5;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;
	assign s_tready = rdy1;

	// valid bits of the stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= s_tvalid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
			if (rdy5) v_s5 <= v_s4;
			if (rdy6) v_s6 <= v_s5;
			if (rdy7) v_s7 <= v_s6;
			if (rdy8) v_s8 <= sq_out_valid;
			if (rdy9) v_s9 <= v_s8;
		end
	end

	// stage 1: offset of origin from center
	logic signed [DW-1:0]   dx_s1, dy_s1, dz_s1;
	logic signed [DIRW-1:0] ux_s1, uy_s1, uz_s1;
	always_ff @(posedge clk) begin
		if (rdy1) begin
			dx_s1 <= DW'(ox) - DW'(center_x_q);
			dy_s1 <= DW'(oy) - DW'(center_y_q);
			dz_s1 <= DW'(oz) - DW'(center_z_q);
			ux_s1 <= dx_in;
			uy_s1 <= dy_in;
			uz_s1 <= dz_in;
		end
	end

	// stage 2: products for d.dir, d.d and r*r
	logic signed [PW-1:0]  px_s2, py_s2, pz_s2;
	logic signed [SQW-1:0] qx_s2, qy_s2, qz_s2;
	logic [RRW-1:0]        rr_s2;
	always_ff @(posedge clk) begin
		if (rdy2) begin
			px_s2 <= PW'(dx_s1) * PW'(ux_s1);
			py_s2 <= PW'(dy_s1) * PW'(uy_s1);
			pz_s2 <= PW'(dz_s1) * PW'(uz_s1);
			qx_s2 <= SQW'(dx_s1) * SQW'(dx_s1);
			qy_s2 <= SQW'(dy_s1) * SQW'(dy_s1);
			qz_s2 <= SQW'(dz_s1) * SQW'(dz_s1);
			rr_s2 <= RRW'(radius_q) * RRW'(radius_q);
		end
	end

	// stage 3: b and sum of squares
	logic signed [BW-1:0] b_s3;
	logic [SUMW-1:0]      ss_s3;
	logic [RRW-1:0]       rr_s3;
	always_ff @(posedge clk) begin
		if (rdy3) begin
			b_s3  <= (BW'(px_s2) + BW'(py_s2) + BW'(pz_s2)) <<< 1;
			ss_s3 <= SUMW'(qx_s2) + SUMW'(qy_s2) + SUMW'(qz_s2);
			rr_s3 <= rr_s2;
		end
	end

	// stage 4: magnitude of b and c scaled to 2F fraction bits
	logic signed [BW-1:0]  b_s4;
	logic [MAGW-1:0]       mb_s4;
	logic signed [CCW-1:0] cc_s4;
	always_ff @(posedge clk) begin
		if (rdy4) begin
			b_s4  <= b_s3;
			mb_s4 <= b_s3[BW-1] ? MAGW'(-b_s3) : MAGW'(b_s3);
			cc_s4 <= $signed({1'b0, ss_s3}) - $signed(CCW'(rr_s3));
		end
	end

	// stage 5: partial products of b*b
	logic signed [BW-1:0]  b_s5;
	logic [2*HIW-1:0]      hh_s5;
	logic [HIW+LOW-1:0]    hl_s5;
	logic [2*LOW-1:0]      ll_s5;
	logic signed [CCW-1:0] cc_s5;
	always_ff @(posedge clk) begin
		if (rdy5) begin
			b_s5  <= b_s4;
			hh_s5 <= (2*HIW)'(mb_s4[MAGW-1:LOW]) * (2*HIW)'(mb_s4[MAGW-1:LOW]);
			hl_s5 <= (HIW+LOW)'(mb_s4[MAGW-1:LOW]) * (HIW+LOW)'(mb_s4[LOW-1:0]);
			ll_s5 <= (2*LOW)'(mb_s4[LOW-1:0]) * (2*LOW)'(mb_s4[LOW-1:0]);
			cc_s5 <= cc_s4;
		end
	end

	// stage 6: assemble b*b, scale c
	logic signed [BW-1:0]    b_s6;
	logic [BBW-1:0]          bb_s6;
	logic signed [DISCW-1:0] cs_s6;
	always_ff @(posedge clk) begin
		if (rdy6) begin
			b_s6  <= b_s5;
			bb_s6 <= (BBW'(hh_s5) << (2*LOW)) + (BBW'(hl_s5) << (LOW+1)) + BBW'(ll_s5);
			cs_s6 <= DISCW'(cc_s5) <<< CSH;
		end
	end

	// stage 7: discriminant and hit decision
	logic signed [DISCW-1:0] disc_c;
	logic [DISCW-1:0]        rad_s7;
	rsi_side_t               side_s7;
	assign disc_c = $signed(DISCW'(bb_s6)) - cs_s6;
	always_ff @(posedge clk) begin
		if (rdy7) begin
			side_s7.hit <= !disc_c[DISCW-1] && (disc_c != '0);
			side_s7.b   <= b_s6;
			rad_s7      <= disc_c[DISCW-1] ? '0 : disc_c;
		end
	end

	// square root of the discriminant
	logic [SQRTW-1:0] sq_root;
	rsi_side_t        sq_side;
	rsi_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s7),
		.in_ready  (sq_in_ready),
		.in_rad    (rad_s7),
		.in_side   (side_s7),
		.out_valid (sq_out_valid),
		.out_ready (rdy8),
		.out_root  (sq_root),
		.out_side  (sq_side)
	);

	// stage 8: both roots halved to F fraction bits, less epsilon
	logic signed [NW-1:0] bx_c, sx_c, n1_c, n2_c;
	logic signed [NW-1:0] r1_s8, r2_s8;
	logic                 hit_s8;
	assign bx_c = NW'(sq_side.b);
	assign sx_c = $signed({{(NW-SQRTW){1'b0}}, sq_root});
	assign n1_c = -bx_c - sx_c;
	assign n2_c = sx_c - bx_c;
	always_ff @(posedge clk) begin
		if (rdy8) begin
			r1_s8  <= (n1_c >>> (FRAC_BITS + 1)) - NW'(1);
			r2_s8  <= (n2_c >>> (FRAC_BITS + 1)) - NW'(1);
			hit_s8 <= sq_side.hit;
		end
	end

	// stage 9: pick the root, clamp, output register
	logic signed [NW-1:0] root_c;
	logic                 hit_s9, sat_s9;
	logic signed [CW-1:0] dist_s9;
	assign root_c = (r1_s8 > NW'(0)) ? r1_s8 : r2_s8;
	always_ff @(posedge clk) begin
		if (rdy9) begin
			hit_s9 <= hit_s8;
			priority if (!hit_s8) begin
				dist_s9 <= MISS_DIST;
				sat_s9  <= 1'b0;
			end else if (root_c > NW'(DIST_MAX)) begin
				dist_s9 <= DIST_MAX;
				sat_s9  <= 1'b1;
			end else if (root_c < NW'(DIST_MIN)) begin
				dist_s9 <= DIST_MIN;
				sat_s9  <= 1'b1;
			end else begin
				dist_s9 <= root_c[CW-1:0];
				sat_s9  <= 1'b0;
			end
		end
	end

	assign m_tvalid = v_s9;
	assign m_tdata  = {{(OUT_W-CW-2){1'b0}}, sat_s9, dist_s9, hit_s9};

	// checks on the result and the stall logic
	`RSI_ASSERT_IMP(a_miss_value, v_s9 && !hit_s9, dist_s9 == MISS_DIST && !sat_s9, "miss result malformed")
	`RSI_ASSERT_IMP(a_sat_rail, v_s9 && sat_s9, dist_s9 == DIST_MAX || dist_s9 == DIST_MIN, "saturated distance off rail")
	`RSI_ASSERT_NXT(a_s1_hold, v_s1 && !rdy2, v_s1, "stage 1 request lost under stall")

endmodule
